// ===== src/i2cm_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
// No dependencies; used by i2cm_front, i2cm_back and the top level.
package i2cm_pkg;

    // Command codes carried by the action field
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // Phase indexes that matter inside the write and read sequences
    localparam logic [4:0] STEP_WR_LAST_BIT = 5'd24;
    localparam logic [4:0] STEP_WR_ACK      = 5'd25;
    localparam logic [4:0] STEP_RD_LAST_BIT = 5'd16;
    localparam logic [4:0] STEP_RD_ACK_DRV  = 5'd17;
    localparam logic [4:0] STEP_RD_ACK_HIGH = 5'd18;

    // Phase counts per command
    localparam logic [5:0] PHASES_START_STOP = 6'd3;
    localparam logic [5:0] PHASES_WRITE      = 6'd25;
    localparam logic [5:0] PHASES_WRITE_ACK  = 6'd27;
    localparam logic [5:0] PHASES_READ       = 6'd20;
    localparam logic [5:0] PHASES_IDLE       = 6'd1;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd5;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] write_byte;
        logic       ack_flag;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       no_ack;
        logic       refused;
    } t_res;

    // Classified request handed from the front to the back
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] write_byte;
        logic       ack_flag;
        logic       sda_in;
    } t_req;

    typedef struct packed {
        logic scl;
        logic sda;
        logic drv;
    } t_pins;

endpackage

// ===== src/i2c_master_bit_engine_top.sv =====
// Top level of the I2C master bit engine: request queue front end and pin sequencer.
// Depends on i2cm_pkg, i2cm_front and i2cm_back.
// A request is registered in the queue, then its result in the result register, where
// it is held until taken. Throughput: one request per cycle while the result register
// is free or being taken. Reset (synchronous, active low) empties the queue, sets
// phase_ticks to 5, idles the sequencer and drives SCL and SDA high.
module i2c_master_bit_engine_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  i2cm_pkg::t_item i_item,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output i2cm_pkg::t_res  o_res,
    input  logic            i_cfg_wr_en,
    input  logic [15:0]     i_cfg_wr_data
);

    logic           w_q_valid;
    i2cm_pkg::t_req w_q_req;
    logic           w_q_pop;

    i2cm_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_item     (i_item),
        .o_q_valid  (w_q_valid),
        .o_q_req    (w_q_req),
        .i_q_pop    (w_q_pop)
    );

    i2cm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_req       (w_q_req),
        .o_q_pop       (w_q_pop),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_res         (o_res)
    );

endmodule

// ===== src/i2cm_front.sv =====
// Front end: accepts ticks, classifies the action field and queues requests.
// Depends on i2cm_pkg.
module i2cm_front #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  i2cm_pkg::t_item i_item,
    output logic            o_q_valid,
    output i2cm_pkg::t_req  o_q_req,
    input  logic            i_q_pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    i2cm_pkg::t_req r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    i2cm_pkg::t_req w_req;
    logic           w_push;
    logic           w_pop;

    // Codes outside the command range are treated as no command
    always_comb begin
        w_req.write_byte = i_item.write_byte;
        w_req.ack_flag   = i_item.ack_flag;
        w_req.sda_in     = i_item.sda_in;
        unique case (i_item.action)
            i2cm_pkg::CMD_START,
            i2cm_pkg::CMD_STOP,
            i2cm_pkg::CMD_WRITE,
            i2cm_pkg::CMD_READ: w_req.cmd = i_item.action;
            default:            w_req.cmd = i2cm_pkg::CMD_NONE;
        endcase
    end

    assign o_in_ready = (r_count != CW'(DEPTH));
    assign o_q_valid  = (r_count != '0);
    assign o_q_req    = r_mem[r_rd_ptr];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = o_q_valid && i_q_pop;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        priority if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_req;
        end
    end

endmodule

// ===== src/i2cm_back.sv =====
// Back end: pin sequencer that runs one queued tick per cycle into a result register
// while that register is free or being taken. Depends on i2cm_pkg.
module i2cm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  i2cm_pkg::t_req i_q_req,
    output logic           o_q_pop,
    input  logic           i_cfg_wr_en,
    input  logic [15:0]    i_cfg_wr_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output i2cm_pkg::t_res o_res
);

    logic [15:0]       r_phase_ticks;
    logic [15:0]       r_tick_cnt, n_tick_cnt;
    logic [4:0]        r_step, n_step;
    logic [2:0]        r_cmd, n_cmd;
    logic [7:0]        r_shift, n_shift;
    logic              r_ack_req, n_ack_req;
    i2cm_pkg::t_pins   r_pins, n_pins;
    logic              r_no_ack, n_no_ack;
    logic [7:0]        r_read, n_read;
    logic              r_out_valid;
    i2cm_pkg::t_res    r_res, n_res;
    logic              w_take;

    // Pin levels set on the first tick of a phase
    function automatic i2cm_pkg::t_pins f_enter(
        input logic [2:0]      cmd,
        input logic [4:0]      s,
        input logic [7:0]      sh,
        input logic            ar,
        input i2cm_pkg::t_pins p
    );
        i2cm_pkg::t_pins r;
        logic [4:0]      x;
        logic [7:0]      prod;
        logic [2:0]      q;
        logic [4:0]      k;
        r    = p;
        x    = s - 5'd1;
        // x / 3 for x < 24 via multiply by 11 and shift
        prod = {3'b000, x} * 8'd11;
        q    = prod[7:5];
        k    = x - {1'b0, q, 1'b0} - {2'b00, q};
        unique case (cmd)
            i2cm_pkg::CMD_START: begin
                priority if (s == 5'd0) begin
                    r.scl = 1'b1; r.sda = 1'b1; r.drv = 1'b1;
                end else if (s == 5'd1) begin
                    r.sda = 1'b0;
                end else begin
                    r.scl = 1'b0;
                end
            end
            i2cm_pkg::CMD_STOP: begin
                priority if (s == 5'd0) begin
                    r.scl = 1'b0; r.sda = 1'b0; r.drv = 1'b1;
                end else if (s == 5'd1) begin
                    r.scl = 1'b1;
                end else begin
                    r.sda = 1'b1;
                end
            end
            i2cm_pkg::CMD_WRITE: begin
                priority if (s == 5'd0) begin
                    r.drv = 1'b1; r.scl = 1'b0;
                end else if (s <= i2cm_pkg::STEP_WR_LAST_BIT) begin
                    priority if (k == 5'd0) begin
                        r.sda = sh[3'd7 - q];
                    end else if (k == 5'd1) begin
                        r.scl = 1'b1;
                    end else begin
                        r.scl = 1'b0;
                    end
                end else if (s == i2cm_pkg::STEP_WR_ACK) begin
                    r.drv = 1'b0; r.scl = 1'b1;
                end else begin
                    r.scl = 1'b0;
                end
            end
            i2cm_pkg::CMD_READ: begin
                priority if (s == 5'd0) begin
                    r.drv = 1'b0;
                end else if (s <= i2cm_pkg::STEP_RD_LAST_BIT) begin
                    r.scl = s[0];
                end else if (s == i2cm_pkg::STEP_RD_ACK_DRV) begin
                    r.drv = 1'b1; r.scl = 1'b0; r.sda = !ar;
                end else if (s == i2cm_pkg::STEP_RD_ACK_HIGH) begin
                    r.scl = 1'b1;
                end else begin
                    r.scl = 1'b0;
                end
            end
            default: r = p;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] f_phases(input logic [2:0] cmd, input logic ar);
        logic [5:0] n;
        unique case (cmd)
            i2cm_pkg::CMD_START,
            i2cm_pkg::CMD_STOP:  n = i2cm_pkg::PHASES_START_STOP;
            i2cm_pkg::CMD_WRITE: n = ar ? i2cm_pkg::PHASES_WRITE_ACK
                                        : i2cm_pkg::PHASES_WRITE;
            i2cm_pkg::CMD_READ:  n = i2cm_pkg::PHASES_READ;
            default:             n = i2cm_pkg::PHASES_IDLE;
        endcase
        return n;
    endfunction

    // Take the next request whenever the result register is free or draining
    assign w_take      = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop     = w_take;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    always_comb begin : comb_step
        logic        refused;
        logic        done;
        logic [15:0] pt;
        logic [15:0] tc_inc;
        logic [5:0]  s_inc;
        n_tick_cnt = r_tick_cnt;
        n_step     = r_step;
        n_cmd      = r_cmd;
        n_shift    = r_shift;
        n_ack_req  = r_ack_req;
        n_pins     = r_pins;
        n_no_ack   = r_no_ack;
        n_read     = r_read;
        refused    = 1'b0;
        done       = 1'b0;
        pt         = (r_phase_ticks == '0) ? 16'd1 : r_phase_ticks;

        if (r_cmd == i2cm_pkg::CMD_NONE) begin
            if (i_q_req.cmd != i2cm_pkg::CMD_NONE) begin
                n_cmd      = i_q_req.cmd;
                n_step     = '0;
                n_tick_cnt = '0;
                n_ack_req  = i_q_req.ack_flag;
                if (i_q_req.cmd == i2cm_pkg::CMD_WRITE) begin
                    n_shift  = i_q_req.write_byte;
                    n_no_ack = 1'b0;
                end
                if (i_q_req.cmd == i2cm_pkg::CMD_READ) begin
                    n_shift = '0;
                end
                n_pins = f_enter(n_cmd, n_step, n_shift, n_ack_req, n_pins);
            end
        end else if (i_q_req.cmd != i2cm_pkg::CMD_NONE) begin
            refused = 1'b1;
        end

        n_res.scl_level = n_pins.scl;
        n_res.sda_drive = n_pins.drv;
        n_res.sda_level = n_pins.drv & n_pins.sda;

        tc_inc = n_tick_cnt + 16'd1;
        s_inc  = {1'b0, n_step} + 6'd1;
        if (n_cmd != i2cm_pkg::CMD_NONE) begin
            if (tc_inc >= pt) begin
                if (n_cmd == i2cm_pkg::CMD_WRITE && n_step == i2cm_pkg::STEP_WR_ACK
                        && i_q_req.sda_in) begin
                    n_no_ack = 1'b1;
                end
                // Sample on the last tick of each SCL-high data phase
                if (n_cmd == i2cm_pkg::CMD_READ && n_step[0] && n_step != 5'd0
                        && n_step <= i2cm_pkg::STEP_RD_LAST_BIT) begin
                    n_shift = {n_shift[6:0], i_q_req.sda_in};
                end
                n_tick_cnt = '0;
                if (s_inc >= f_phases(n_cmd, n_ack_req)) begin
                    done = 1'b1;
                    if (n_cmd == i2cm_pkg::CMD_READ) begin
                        n_read = n_shift;
                    end
                    n_cmd  = i2cm_pkg::CMD_NONE;
                    n_step = '0;
                end else begin
                    n_step = s_inc[4:0];
                    n_pins = f_enter(n_cmd, n_step, n_shift, n_ack_req, n_pins);
                end
            end else begin
                n_tick_cnt = tc_inc;
            end
        end

        n_res.busy_res  = (n_cmd != i2cm_pkg::CMD_NONE);
        n_res.done_res  = done;
        n_res.read_data = n_read;
        n_res.no_ack    = n_no_ack;
        n_res.refused   = refused;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= i2cm_pkg::PHASE_TICKS_RESET;
            r_tick_cnt    <= '0;
            r_step        <= '0;
            r_cmd         <= i2cm_pkg::CMD_NONE;
            r_shift       <= '0;
            r_ack_req     <= 1'b0;
            r_pins        <= '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
            r_no_ack      <= 1'b0;
            r_read        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_phase_ticks <= i_cfg_wr_data;
            end
            if (w_take) begin
                r_tick_cnt <= n_tick_cnt;
                r_step     <= n_step;
                r_cmd      <= n_cmd;
                r_shift    <= n_shift;
                r_ack_req  <= n_ack_req;
                r_pins     <= n_pins;
                r_no_ack   <= n_no_ack;
                r_read     <= n_read;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res <= n_res;
        end
    end

endmodule

// ===== sim/i2c_master_bit_engine_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for i2c_master_bit_engine_top: directed and random ticks against a pin predictor.
// Depends on i2cm_pkg and the RTL under src/.
module i2c_master_bit_engine_top_tb;
    import i2cm_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        o_in_ready;
    t_item       item;
    logic        o_out_valid;
    logic        out_ready;
    t_res        o_res;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    t_item pending_ticks[$];
    t_res  tick_results[$];
    int    errors;
    int    cycles;
    int    gap_left;
    int    stall_left;
    bit    gap_en;
    bit    stall_en;
    int    gen_pt;

    // Predicted sequencer state
    logic [15:0] m_pt;
    logic [15:0] m_tick;
    logic [4:0]  m_step;
    logic [2:0]  m_cmd;
    logic [7:0]  m_shift;
    logic        m_ackreq;
    logic        m_scl;
    logic        m_sda;
    logic        m_drv;
    logic        m_noack;
    logic [7:0]  m_rdata;

    i2c_master_bit_engine_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_item        (item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_res         (o_res),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Set pin levels on the first tick of the current phase
    function automatic void load_phase_pins();
        int k;
        int b;
        case (m_cmd)
            CMD_START: begin
                if (m_step == 0) begin
                    m_scl = 1'b1; m_sda = 1'b1; m_drv = 1'b1;
                end else if (m_step == 1) m_sda = 1'b0;
                else m_scl = 1'b0;
            end
            CMD_STOP: begin
                if (m_step == 0) begin
                    m_scl = 1'b0; m_sda = 1'b0; m_drv = 1'b1;
                end else if (m_step == 1) m_scl = 1'b1;
                else m_sda = 1'b1;
            end
            CMD_WRITE: begin
                if (m_step == 0) begin
                    m_drv = 1'b1; m_scl = 1'b0;
                end else if (m_step <= STEP_WR_LAST_BIT) begin
                    k = (m_step - 1) % 3;
                    b = (m_step - 1) / 3;
                    if (k == 0) m_sda = m_shift[7 - b];
                    else if (k == 1) m_scl = 1'b1;
                    else m_scl = 1'b0;
                end else if (m_step == STEP_WR_ACK) begin
                    m_drv = 1'b0; m_scl = 1'b1;
                end else m_scl = 1'b0;
            end
            CMD_READ: begin
                if (m_step == 0) m_drv = 1'b0;
                else if (m_step <= STEP_RD_LAST_BIT) m_scl = m_step[0];
                else if (m_step == STEP_RD_ACK_DRV) begin
                    m_drv = 1'b1; m_scl = 1'b0; m_sda = ~m_ackreq;
                end else if (m_step == STEP_RD_ACK_HIGH) m_scl = 1'b1;
                else m_scl = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // One tick of the bus sequencer: pins driven this tick and status after it
    function automatic t_res advance_sequencer(t_item it);
        t_res        r;
        logic        is_cmd;
        logic [15:0] pt;
        int          last;
        r = '0;
        is_cmd = (it.action >= CMD_START) && (it.action <= CMD_READ);
        if (m_cmd == CMD_NONE) begin
            if (is_cmd) begin
                m_cmd = it.action;
                m_step = '0;
                m_tick = '0;
                m_ackreq = it.ack_flag;
                if (it.action == CMD_WRITE) begin
                    m_shift = it.write_byte;
                    m_noack = 1'b0;
                end
                if (it.action == CMD_READ) m_shift = '0;
                load_phase_pins();
            end
        end else if (is_cmd) r.refused = 1'b1;

        r.scl_level = m_scl;
        r.sda_drive = m_drv;
        r.sda_level = m_drv & m_sda;

        if (m_cmd != CMD_NONE) begin
            pt = (m_pt == 0) ? 16'd1 : m_pt;
            m_tick = m_tick + 16'd1;
            if (m_tick >= pt) begin
                if (m_cmd == CMD_WRITE && m_step == STEP_WR_ACK && it.sda_in) m_noack = 1'b1;
                if (m_cmd == CMD_READ && m_step >= 1 && m_step <= STEP_RD_LAST_BIT && m_step[0])
                    m_shift = {m_shift[6:0], it.sda_in};
                m_tick = '0;
                case (m_cmd)
                    CMD_START, CMD_STOP: last = PHASES_START_STOP;
                    CMD_WRITE: last = m_ackreq ? PHASES_WRITE_ACK : PHASES_WRITE;
                    CMD_READ: last = PHASES_READ;
                    default: last = PHASES_IDLE;
                endcase
                if (int'(m_step) + 1 >= last) begin
                    r.done_res = 1'b1;
                    if (m_cmd == CMD_READ) m_rdata = m_shift;
                    m_cmd = CMD_NONE;
                    m_step = '0;
                end else begin
                    m_step = m_step + 5'd1;
                    load_phase_pins();
                end
            end
        end
        r.busy_res = (m_cmd != CMD_NONE);
        r.read_data = m_rdata;
        r.no_ack = m_noack;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Request driver
    always @(posedge i_clk) begin : drv
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && o_in_ready) tick_results.push_back(advance_sequencer(item));
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_ticks.size() > 0) begin
                    item <= pending_ticks.pop_front();
                    in_valid <= 1'b1;
                    gap_left <= gap_en ? pick_gap() : 0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin : mon
        t_res want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (tick_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, o_res);
                    errors++;
                end else begin
                    want = tick_results.pop_front();
                    check_field("scl_level", want.scl_level, o_res.scl_level);
                    check_field("sda_level", want.sda_level, o_res.sda_level);
                    check_field("sda_drive", want.sda_drive, o_res.sda_drive);
                    check_field("busy_res", want.busy_res, o_res.busy_res);
                    check_field("done_res", want.done_res, o_res.done_res);
                    check_field("read_data", want.read_data, o_res.read_data);
                    check_field("no_ack", want.no_ack, o_res.no_ack);
                    check_field("refused", want.refused, o_res.refused);
                end
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                out_ready <= 1'b1;
                stall_left <= stall_en ? pick_gap() : 0;
            end
        end
    end

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_ticks.size() != 0 || in_valid || tick_results.size() != 0);
    endtask

    // Write phase_ticks with the pipeline empty; the sequencer may still be mid-command
    task automatic write_phase_ticks(input logic [15:0] value);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        m_pt = value;
        gen_pt = (value == 0) ? 1 : value;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    // Queue one command tick followed by enough ticks to let it run out
    task automatic add_sequence(input logic [2:0] act, input logic [7:0] wbyte, input logic ack,
                                input int sda_mode, input int noise_pct);
        t_item it;
        int    phases;
        case (act)
            CMD_START, CMD_STOP: phases = PHASES_START_STOP;
            CMD_WRITE: phases = ack ? PHASES_WRITE_ACK : PHASES_WRITE;
            CMD_READ: phases = PHASES_READ;
            default: phases = PHASES_IDLE;
        endcase
        for (int i = 0; i < phases * gen_pt; i++) begin
            if (i == 0) begin
                it.action = act;
                it.write_byte = wbyte;
                it.ack_flag = ack;
            end else begin
                if ($urandom_range(0, 99) < noise_pct) it.action = 3'($urandom_range(1, 7));
                else it.action = CMD_NONE;
                it.write_byte = 8'($urandom);
                it.ack_flag = 1'($urandom);
            end
            it.sda_in = (sda_mode == 2) ? 1'($urandom) : 1'(sda_mode);
            pending_ticks.push_back(it);
        end
    endtask

    task automatic add_random_ticks(input int count);
        int    goal;
        t_item it;
        goal = pending_ticks.size() + count;
        while (pending_ticks.size() < goal) begin
            if ($urandom_range(0, 99) < 85) begin
                add_sequence(3'($urandom_range(CMD_START, CMD_READ)), 8'($urandom),
                             1'($urandom), 2, 3);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    it = t_item'(13'($urandom));
                    pending_ticks.push_back(it);
                end
            end
        end
    endtask

    initial begin
        t_item it;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        item = '0;
        out_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        errors = 0;
        cycles = 0;
        gap_en = 1'b1;
        stall_en = 1'b1;
        m_pt = PHASE_TICKS_RESET;
        gen_pt = PHASE_TICKS_RESET;
        m_tick = '0;
        m_step = '0;
        m_cmd = CMD_NONE;
        m_shift = '0;
        m_ackreq = 1'b0;
        m_scl = 1'b1;
        m_sda = 1'b1;
        m_drv = 1'b1;
        m_noack = 1'b0;
        m_rdata = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset value of phase_ticks
        add_sequence(CMD_START, 8'h00, 1'b0, 1, 0);
        add_sequence(CMD_STOP, 8'hFF, 1'b1, 2, 0);
        wait_drained();

        // Zero phase_ticks acts as one; directed commands
        write_phase_ticks(16'd0);
        for (int a = 5; a <= 7; a++) begin
            it = '0;
            it.action = 3'(a);
            it.sda_in = 1'(a);
            pending_ticks.push_back(it);
        end
        add_sequence(CMD_START, 8'h00, 1'b0, 1, 0);
        add_sequence(CMD_WRITE, 8'hFF, 1'b1, 1, 100);
        add_sequence(CMD_WRITE, 8'h00, 1'b0, 0, 0);
        add_sequence(CMD_WRITE, 8'h80, 1'b1, 0, 0);
        add_sequence(CMD_READ, 8'h00, 1'b1, 1, 0);
        add_sequence(CMD_READ, 8'hA5, 1'b0, 0, 0);
        add_sequence(CMD_STOP, 8'h00, 1'b0, 2, 0);
        wait_drained();

        write_phase_ticks(16'd1);
        add_random_ticks(170);
        wait_drained();

        // Largest phase_ticks, then shrink it while a start is still in its first phase
        write_phase_ticks(16'hFFFF);
        add_sequence(CMD_START, 8'h00, 1'b0, 2, 0);
        while (pending_ticks.size() > 30) void'(pending_ticks.pop_back());
        wait_drained();
        write_phase_ticks(16'd3);
        gap_en = 1'b0;
        stall_en = 1'b0;
        add_random_ticks(170);
        wait_drained();

        write_phase_ticks(16'd2);
        gap_en = 1'b1;
        stall_en = 1'b1;
        add_random_ticks(170);
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== sim.f =====
src/i2cm_pkg.sv
src/i2cm_front.sv
src/i2cm_back.sv
src/i2c_master_bit_engine_top.sv
sim/i2c_master_bit_engine_top_tb.sv
